>>> rtl/gfx_pkg.sv
package gfx_pkg;

   localparam int IN_W      = 12;
   localparam int SAMPLE_W  = 16;
   localparam int MIDPOINT  = 2047;
   localparam int SAT16     = 65535;
   localparam int HIST_W    = 32;
   localparam int ACC_W     = 60;
   localparam int Y_W       = 42;
   localparam int MUL_A_W   = 34;
   localparam int MUL_B_W   = 25;
   localparam int MUL_P_W   = 59;
   localparam int LEN_W     = 21;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 17;
   localparam int XN_SH     = 12;
   localparam int Q_SH      = 20;
   localparam int M10       = 13421773;
   localparam int SH10      = 27;
   localparam int M100      = 10737419;
   localparam int SH100     = 30;
   localparam int RV_STEP   = 500;
   localparam longint EQ_SAT_PROD = 64'sd1677721600;

   typedef struct packed {
      logic [3:0]  effect_enables;
      logic [10:0] clip_span;
      logic [6:0]  eq_tone;
      logic [6:0]  eq_level;
      logic [16:0] delay_length;
      logic [3:0]  delay_level;
      logic [6:0]  reverb_time;
   } gfx_cfg_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_EFFECT_ENABLES = 3'd0,
      CSR_CLIP_SPAN      = 3'd1,
      CSR_EQ_TONE        = 3'd2,
      CSR_EQ_LEVEL       = 3'd3,
      CSR_DELAY_LENGTH   = 3'd4,
      CSR_DELAY_LEVEL    = 3'd5,
      CSR_REVERB_TIME    = 3'd6
   } gfx_csr_type;

   typedef enum logic [4:0] {
      ST_CLEAR, ST_IDLE, ST_CLIP,
      ST_EQ_XN, ST_EQ_MAC, ST_EQ_SUM, ST_EQ_LVL, ST_EQ_DIV, ST_EQ_Q,
      ST_DLY_RD, ST_DLY_WR, ST_DLY_RD2, ST_DLY_MUL, ST_DLY_DIV, ST_DLY_FIN,
      ST_RV_RD, ST_RV_WR, ST_RV_RD2, ST_RV_ACC, ST_RV_MUL, ST_RV_FIN,
      ST_BOOST, ST_DONE
   } gfx_state_type;

   function automatic longint qp(input longint n);
      return (n * 64'sd1048576 + 64'sd5000000000) / 64'sd10000000000;
   endfunction

   localparam longint EQ_TAB [4][7] = '{
      '{-qp(64'sd1742373434), qp(64'sd4242847127), -qp(64'sd11742373434),
        qp(64'sd19113247840), -qp(64'sd36016161772), qp(64'sd52429097719),
        (64'sd1048576000000000 + 64'sd3084091054 / 2) / 64'sd3084091054},
      '{-qp(64'sd3981522939), qp(64'sd18048015305), -qp(64'sd33585222750),
        qp(64'sd29448662203), -qp(64'sd37885487581), qp(64'sd55882754232),
        (64'sd1048576000000000 + 64'sd1595290011 / 2) / 64'sd1595290011},
      '{-qp(64'sd4954364568), qp(64'sd22889737155), -qp(64'sd40847207924),
        qp(64'sd32910462235), -qp(64'sd39720369081), qp(64'sd59442692998),
        (64'sd1048576000000000 + 64'sd1423664055 / 2) / 64'sd1423664055},
      '{-qp(64'sd9048692656), qp(64'sd37087063213), -qp(64'sd57027465052),
        qp(64'sd38989090873), -qp(64'sd39987658490), qp(64'sd59975320787),
        (64'sd1048576000000000 + 64'sd1051253417 / 2) / 64'sd1051253417}
   };

   function automatic logic signed [MUL_B_W-1:0] eq_coef(input logic [1:0] sel,
                                                          input logic [2:0] k);
      return MUL_B_W'(EQ_TAB[sel][k]);
   endfunction

   function automatic logic [16:0] rv_base(input logic [2:0] ln);
      logic [16:0] b;
      case (ln)
         3'd0, 3'd5: b = 17'd10000;
         3'd1, 3'd3, 3'd6: b = 17'd30000;
         3'd2, 3'd7: b = 17'd50000;
         3'd4: b = 17'd20000;
         default: b = 17'd10000;
      endcase
      return b;
   endfunction

endpackage

>>> rtl/gfx_mul.sv
module gfx_mul (
   input  logic                                 clock,
   input  logic signed [gfx_pkg::MUL_A_W-1:0]   a,
   input  logic signed [gfx_pkg::MUL_B_W-1:0]   b,
   output logic signed [gfx_pkg::MUL_P_W-1:0]   p_ff
);
   import gfx_pkg::*;

   always_ff @(posedge clock) begin
      p_ff <= MUL_P_W'(a) * MUL_P_W'(b);
   end

endmodule

>>> rtl/gfx_ram.sv
module gfx_ram #(
   parameter int DEPTH = 65536,
   parameter int WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata_ff
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

endmodule

>>> rtl/gfx_core.sv
module gfx_core #(
   parameter int ECHO_DEPTH        = 65536,
   parameter int REVERB_LINE_DEPTH = 131072,
   parameter int REVERB_LINES      = 5
) (
   input  logic                            clock,
   input  logic                            reset,
   input  gfx_pkg::gfx_cfg_type            cfg,
   input  logic                            start,
   input  logic [gfx_pkg::IN_W-1:0]        sample,
   output logic                            ready,
   input  logic                            out_free,
   output logic                            done,
   output logic [gfx_pkg::SAMPLE_W-1:0]    result
);
   import gfx_pkg::*;

   localparam int DPW     = $clog2(ECHO_DEPTH);
   localparam int RPW     = $clog2(REVERB_LINE_DEPTH);
   localparam int RV_SIZE = REVERB_LINES * REVERB_LINE_DEPTH;
   localparam int RAW     = $clog2(RV_SIZE);
   localparam int LN_W    = (REVERB_LINES > 1) ? $clog2(REVERB_LINES) : 1;
   localparam int CLR_MAX = (ECHO_DEPTH > RV_SIZE) ? ECHO_DEPTH : RV_SIZE;
   localparam int CW      = $clog2(CLR_MAX);
   localparam int SUM_W   = 19;

   gfx_state_type state_ff, state_in;
   logic [SAMPLE_W-1:0]      x_ff, x_in;
   logic [2:0]               k_ff, k_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [HIST_W-1:0] xn_ff, xn_in;
   logic signed [HIST_W-1:0] hin_ff [4];
   logic signed [HIST_W-1:0] hin_in [4];
   logic signed [HIST_W-1:0] hout_ff [4];
   logic signed [HIST_W-1:0] hout_in [4];
   logic [DPW-1:0]           dptr_ff, dptr_in;
   logic [RPW-1:0]           rptr_ff [REVERB_LINES];
   logic [RPW-1:0]           rptr_in [REVERB_LINES];
   logic [LN_W-1:0]          ln_ff, ln_in;
   logic [RAW-1:0]           base_ff, base_in;
   logic [SUM_W-1:0]         sum_ff, sum_in;
   logic [CW-1:0]            clr_ff, clr_in;

   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [MUL_P_W-1:0] mul_p;

   logic                dly_we, rv_we;
   logic [DPW-1:0]      dly_waddr;
   logic [RAW-1:0]      rv_waddr, rv_addr;
   logic [SAMPLE_W-1:0] dly_wdata, rv_wdata, dly_rd, rv_rd;

   logic [1:0]          sel;
   logic [IN_W-1:0]     clip_hi, clip_lo, clipped;
   logic [3:0]          dly_lvl;
   logic [LEN_W-1:0]    dly_len, dly_inc, rv_len_raw, rv_len, rv_inc;
   logic [DPW-1:0]      dly_nxt;
   logic [RPW-1:0]      rv_cur, rv_nxt;
   logic                ln_last;
   logic signed [Y_W-1:0] y_sum;
   logic signed [HIST_W-1:0] y_sat;
   logic                prod_zero, prod_sat;
   logic [17:0]         dly_fin, boost;
   logic [17:0]         rv_fin;
   logic [16:0]         eq_q;
   gfx_state_type after_clip, after_eq, after_dly, after_rv;

   gfx_mul u_mul (.clock(clock), .a(mul_a), .b(mul_b), .p_ff(mul_p));

   gfx_ram #(.DEPTH(ECHO_DEPTH), .WIDTH(SAMPLE_W)) u_dly_ram (
      .clock(clock), .we(dly_we), .waddr(dly_waddr), .wdata(dly_wdata),
      .raddr(dptr_ff), .rdata_ff(dly_rd));

   gfx_ram #(.DEPTH(RV_SIZE), .WIDTH(SAMPLE_W)) u_rv_ram (
      .clock(clock), .we(rv_we), .waddr(rv_waddr), .wdata(rv_wdata),
      .raddr(rv_addr), .rdata_ff(rv_rd));

   // stage helpers
   always_comb begin
      sel = (cfg.eq_tone <= 7'd20) ? 2'd0 : (cfg.eq_tone <= 7'd60) ? 2'd1 :
            (cfg.eq_tone <= 7'd80) ? 2'd2 : 2'd3;
      clip_hi = IN_W'(MIDPOINT) + IN_W'(cfg.clip_span);
      clip_lo = IN_W'(MIDPOINT) - IN_W'(cfg.clip_span);
      clipped = x_ff[IN_W-1:0];
      if (clipped > clip_hi) begin
         clipped = clip_hi;
      end
      if (clipped < clip_lo) begin
         clipped = clip_lo;
      end
      dly_lvl = (cfg.delay_level > 4'd11) ? 4'd0 : cfg.delay_level;
      dly_len = (LEN_W'(cfg.delay_length) > LEN_W'(ECHO_DEPTH)) ?
                LEN_W'(ECHO_DEPTH) : LEN_W'(cfg.delay_length);
      dly_inc = LEN_W'(dptr_ff) + LEN_W'(1);
      dly_nxt = (dly_inc >= dly_len) ? '0 : DPW'(dly_inc);
      rv_len_raw = LEN_W'(rv_base(3'(ln_ff))) + LEN_W'(cfg.reverb_time) * LEN_W'(RV_STEP);
      rv_len = (rv_len_raw > LEN_W'(REVERB_LINE_DEPTH)) ?
               LEN_W'(REVERB_LINE_DEPTH) : rv_len_raw;
      rv_cur = rptr_ff[ln_ff];
      rv_inc = LEN_W'(rv_cur) + LEN_W'(1);
      rv_nxt = (rv_inc >= rv_len) ? '0 : RPW'(rv_inc);
      rv_addr = base_ff + RAW'(rv_cur);
      ln_last = (ln_ff == LN_W'(REVERB_LINES - 1));
      y_sum = Y_W'(hin_ff[0]) + Y_W'(xn_ff) + Y_W'(acc_ff >>> Q_SH);
      if (y_sum > Y_W'(64'sd2147483647)) begin
         y_sat = 32'sh7FFFFFFF;
      end else if (y_sum < -Y_W'(64'sd2147483648)) begin
         y_sat = 32'sh80000000;
      end else begin
         y_sat = HIST_W'(y_sum);
      end
      prod_zero = (mul_p <= 0);
      prod_sat  = (mul_p >= MUL_P_W'(EQ_SAT_PROD));
      eq_q      = mul_p[46:30];
      dly_fin   = (18'(mul_p[43:SH10]) + 18'(x_ff)) >> 1;
      rv_fin    = 18'(mul_p[46:SH10 + 2]);
      boost     = (18'(x_ff) + (18'(x_ff) << 1)) >> 1;
      after_rv   = cfg.effect_enables[0] ? ST_BOOST : ST_DONE;
      after_dly  = cfg.effect_enables[3] ? ST_RV_RD : after_rv;
      after_eq   = cfg.effect_enables[2] ? ST_DLY_RD : after_dly;
      after_clip = cfg.effect_enables[1] ? ST_EQ_XN : after_eq;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:   if (clr_ff == CW'(CLR_MAX - 1)) state_in = ST_IDLE;
         ST_IDLE:    if (start) state_in = ST_CLIP;
         ST_CLIP:    state_in = after_clip;
         ST_EQ_XN:   state_in = ST_EQ_MAC;
         ST_EQ_MAC:  if (k_ff == 3'd6) state_in = ST_EQ_SUM;
         ST_EQ_SUM:  state_in = ST_EQ_LVL;
         ST_EQ_LVL:  state_in = ST_EQ_DIV;
         ST_EQ_DIV:  state_in = (prod_zero || prod_sat) ? after_eq : ST_EQ_Q;
         ST_EQ_Q:    state_in = after_eq;
         ST_DLY_RD:  state_in = ST_DLY_WR;
         ST_DLY_WR:  state_in = ST_DLY_RD2;
         ST_DLY_RD2: state_in = ST_DLY_MUL;
         ST_DLY_MUL: state_in = ST_DLY_DIV;
         ST_DLY_DIV: state_in = ST_DLY_FIN;
         ST_DLY_FIN: state_in = after_dly;
         ST_RV_RD:   state_in = ST_RV_WR;
         ST_RV_WR:   state_in = ln_last ? ST_RV_RD2 : ST_RV_RD;
         ST_RV_RD2:  state_in = ST_RV_ACC;
         ST_RV_ACC:  state_in = ln_last ? ST_RV_MUL : ST_RV_RD2;
         ST_RV_MUL:  state_in = ST_RV_FIN;
         ST_RV_FIN:  state_in = after_rv;
         ST_BOOST:   state_in = ST_DONE;
         ST_DONE:    if (out_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      x_in    = x_ff;
      k_in    = k_ff;
      acc_in  = acc_ff;
      xn_in   = xn_ff;
      hin_in  = hin_ff;
      hout_in = hout_ff;
      dptr_in = dptr_ff;
      rptr_in = rptr_ff;
      ln_in   = ln_ff;
      base_in = base_ff;
      sum_in  = sum_ff;
      clr_in  = clr_ff;
      mul_a   = '0;
      mul_b   = '0;
      dly_we    = 1'b0;
      dly_waddr = dptr_ff;
      dly_wdata = SAMPLE_W'((17'(x_ff) + 17'(dly_rd)) >> 1);
      rv_we     = 1'b0;
      rv_waddr  = rv_addr;
      rv_wdata  = SAMPLE_W'((17'(x_ff) + 17'(rv_rd)) >> 1);
      ready  = (state_ff == ST_IDLE);
      done   = 1'b0;
      result = x_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in    = clr_ff + CW'(1);
            dly_we    = ({1'b0, clr_ff} < (CW + 1)'(ECHO_DEPTH));
            dly_waddr = clr_ff[DPW-1:0];
            dly_wdata = '0;
            rv_we     = ({1'b0, clr_ff} < (CW + 1)'(RV_SIZE));
            rv_waddr  = clr_ff[RAW-1:0];
            rv_wdata  = '0;
         end
         ST_IDLE: begin
            if (start) begin
               x_in = SAMPLE_W'(sample);
            end
         end
         ST_CLIP: begin
            if (cfg.effect_enables[0]) begin
               x_in = SAMPLE_W'(clipped);
            end
         end
         ST_EQ_XN: begin
            mul_a = MUL_A_W'(x_ff);
            mul_b = eq_coef(sel, 3'd6);
            k_in  = 3'd0;
         end
         ST_EQ_MAC: begin
            k_in = k_ff + 3'd1;
            if (k_ff == 3'd0) begin
               xn_in  = HIST_W'(mul_p >>> XN_SH);
               acc_in = '0;
            end else begin
               acc_in = acc_ff + ACC_W'(mul_p);
            end
            case (k_ff)
               3'd0: begin
                  mul_a = MUL_A_W'(hin_ff[1]) + MUL_A_W'(hin_ff[3]);
                  mul_b = eq_coef(sel, 3'd4);
               end
               3'd1: begin
                  mul_a = MUL_A_W'(hin_ff[2]);
                  mul_b = eq_coef(sel, 3'd5);
               end
               3'd2: begin
                  mul_a = MUL_A_W'(hout_ff[0]);
                  mul_b = eq_coef(sel, 3'd0);
               end
               3'd3: begin
                  mul_a = MUL_A_W'(hout_ff[1]);
                  mul_b = eq_coef(sel, 3'd1);
               end
               3'd4: begin
                  mul_a = MUL_A_W'(hout_ff[2]);
                  mul_b = eq_coef(sel, 3'd2);
               end
               3'd5: begin
                  mul_a = MUL_A_W'(hout_ff[3]);
                  mul_b = eq_coef(sel, 3'd3);
               end
               default: begin
                  mul_a = '0;
                  mul_b = '0;
               end
            endcase
         end
         ST_EQ_SUM: begin
            hin_in[0]  = hin_ff[1];
            hin_in[1]  = hin_ff[2];
            hin_in[2]  = hin_ff[3];
            hin_in[3]  = xn_ff;
            hout_in[0] = hout_ff[1];
            hout_in[1] = hout_ff[2];
            hout_in[2] = hout_ff[3];
            hout_in[3] = y_sat;
         end
         ST_EQ_LVL: begin
            mul_a = MUL_A_W'(hout_ff[3]);
            mul_b = MUL_B_W'(8'd50 + 8'(cfg.eq_level));
         end
         ST_EQ_DIV: begin
            if (prod_zero) begin
               x_in = '0;
            end else if (prod_sat) begin
               x_in = SAMPLE_W'(SAT16);
            end
            mul_a = MUL_A_W'(mul_p[30:8]);
            mul_b = MUL_B_W'(M100);
         end
         ST_EQ_Q: begin
            x_in = eq_q[16] ? SAMPLE_W'(SAT16) : eq_q[15:0];
         end
         ST_DLY_WR: begin
            dly_we  = 1'b1;
            dptr_in = dly_nxt;
         end
         ST_DLY_MUL: begin
            mul_a = MUL_A_W'(dly_rd);
            mul_b = MUL_B_W'(5'd5 + 5'(dly_lvl));
         end
         ST_DLY_DIV: begin
            mul_a = MUL_A_W'(mul_p[19:0]);
            mul_b = MUL_B_W'(M10);
         end
         ST_DLY_FIN: begin
            x_in = (dly_fin > 18'(SAT16)) ? SAMPLE_W'(SAT16) : dly_fin[15:0];
         end
         ST_RV_WR: begin
            rv_we          = 1'b1;
            rptr_in[ln_ff] = rv_nxt;
            if (ln_last) begin
               ln_in   = '0;
               base_in = '0;
               sum_in  = '0;
            end else begin
               ln_in   = ln_ff + LN_W'(1);
               base_in = base_ff + RAW'(REVERB_LINE_DEPTH);
            end
         end
         ST_RV_ACC: begin
            sum_in = sum_ff + SUM_W'(rv_rd);
            if (ln_last) begin
               ln_in   = '0;
               base_in = '0;
            end else begin
               ln_in   = ln_ff + LN_W'(1);
               base_in = base_ff + RAW'(REVERB_LINE_DEPTH);
            end
         end
         ST_RV_MUL: begin
            mul_a = MUL_A_W'((23'(x_ff) << 3) + (23'(x_ff) << 1) +
                             (23'(sum_ff) << 3) - 23'(sum_ff));
            mul_b = MUL_B_W'(M10);
         end
         ST_RV_FIN: begin
            x_in = (rv_fin > 18'(SAT16)) ? SAMPLE_W'(SAT16) : rv_fin[15:0];
         end
         ST_BOOST: begin
            x_in = (boost > 18'(SAT16)) ? SAMPLE_W'(SAT16) : boost[15:0];
         end
         ST_DONE: begin
            done = out_free;
         end
         default: begin
            x_in = x_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         k_ff     <= '0;
         dptr_ff  <= '0;
         ln_ff    <= '0;
         base_ff  <= '0;
         xn_ff    <= '0;
         for (int i = 0; i < 4; i++) begin
            hin_ff[i]  <= '0;
            hout_ff[i] <= '0;
         end
         for (int i = 0; i < REVERB_LINES; i++) begin
            rptr_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         k_ff     <= k_in;
         dptr_ff  <= dptr_in;
         ln_ff    <= ln_in;
         base_ff  <= base_in;
         xn_ff    <= xn_in;
         hin_ff   <= hin_in;
         hout_ff  <= hout_in;
         rptr_ff  <= rptr_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff   <= x_in;
      acc_ff <= acc_in;
      sum_ff <= sum_in;
   end

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> (state_ff == ST_IDLE))
      else $error("word taken while busy");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done |=> (state_ff == ST_IDLE))
      else $error("result handed over without return to idle");

   a_mac_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EQ_MAC) |-> (k_ff <= 3'd6))
      else $error("filter term counter overran");

   a_line_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RV_WR || state_ff == ST_RV_ACC) |->
      (ln_ff <= LN_W'(REVERB_LINES - 1)))
      else $error("comb line counter overran");

endmodule

>>> rtl/guitar_effects_chain_top.sv
// the path from accepted word to accepted result is set by the sequencer stepping the
// single shared multiplier and the line stores, each with one read and one write port
// the core takes a new word only after it has handed over the previous result,
// and it waits in its done state while rsp_tready holds the previous result back
// reset: synchronous; after reset a clearing pass over max(ECHO_DEPTH,
// REVERB_LINES*REVERB_LINE_DEPTH) addresses zeroes the line stores before req_tready rises
module guitar_effects_chain_top #(
   parameter int ECHO_DEPTH        = 65536,
   parameter int REVERB_LINE_DEPTH = 131072,
   parameter int REVERB_LINES      = 5
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [15:0]                       req_tdata,   // sample_in [11:0]
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [15:0]                       rsp_tdata,   // sample_out [15:0]
   input  logic                              csr_wr_en,
   input  logic [gfx_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [gfx_pkg::CSR_DAT_W-1:0]     csr_wdata
);
   import gfx_pkg::*;

   gfx_cfg_type         cfg_ff, cfg_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0] rsp_data_ff, rsp_data_in;
   logic                core_ready, core_done, out_free;
   logic [SAMPLE_W-1:0] core_result;

   gfx_core #(
      .ECHO_DEPTH(ECHO_DEPTH),
      .REVERB_LINE_DEPTH(REVERB_LINE_DEPTH),
      .REVERB_LINES(REVERB_LINES)
   ) u_core (
      .clock(clock), .reset(reset), .cfg(cfg_ff),
      .start(req_tvalid && core_ready), .sample(req_tdata[IN_W-1:0]),
      .ready(core_ready), .out_free(out_free), .done(core_done),
      .result(core_result));

   assign req_tready = core_ready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_EFFECT_ENABLES: cfg_in.effect_enables = csr_wdata[3:0];
            CSR_CLIP_SPAN:      cfg_in.clip_span      = csr_wdata[10:0];
            CSR_EQ_TONE:        cfg_in.eq_tone        = csr_wdata[6:0];
            CSR_EQ_LEVEL:       cfg_in.eq_level       = csr_wdata[6:0];
            CSR_DELAY_LENGTH:   cfg_in.delay_length   = csr_wdata[16:0];
            CSR_DELAY_LEVEL:    cfg_in.delay_level    = csr_wdata[3:0];
            CSR_REVERB_TIME:    cfg_in.reverb_time    = csr_wdata[6:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (core_done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = core_result;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.effect_enables <= 4'd0;
         cfg_ff.clip_span      <= 11'd100;
         cfg_ff.eq_tone        <= 7'd0;
         cfg_ff.eq_level       <= 7'd0;
         cfg_ff.delay_length   <= 17'd50000;
         cfg_ff.delay_level    <= 4'd0;
         cfg_ff.reverb_time    <= 7'd0;
         rsp_valid_ff          <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule
